// ----- hdl/ednms_pkg.sv -----
// Shared types, constants and functions of the edge non-maximum suppression block
`timescale 1ns / 1ps
package ednms_pkg;

  localparam int MAX_LINE_WIDTH = 2048;
  localparam int COL_BITS       = $clog2(MAX_LINE_WIDTH);
  localparam int MAX_FRAME_ROWS = 2048;
  localparam int ROW_BITS       = $clog2(MAX_FRAME_ROWS);
  localparam int SAMPLE_BITS    = 16;
  localparam int GRAD_BITS      = 16;
  localparam int CFG_BITS       = 12;
  localparam int CFG_IDX_BITS   = 1;
  localparam int TAN_SHIFT      = 16;
  localparam int PROD_BITS      = GRAD_BITS + 1 + TAN_SHIFT;
  localparam logic [14:0] TAN_NUM = 15'd27146;

  localparam logic [CFG_BITS-1:0] RESET_FRAME_WIDTH  = CFG_BITS'(640);
  localparam logic [CFG_BITS-1:0] RESET_FRAME_HEIGHT = CFG_BITS'(480);
  localparam logic [CFG_BITS-1:0] WIDTH_LIMIT  = CFG_BITS'(MAX_LINE_WIDTH);
  localparam logic [CFG_BITS-1:0] HEIGHT_LIMIT = CFG_BITS'(MAX_FRAME_ROWS);

  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = CFG_IDX_BITS'(1);

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  localparam logic [1:0] DIR_HORIZONTAL = 2'd0;
  localparam logic [1:0] DIR_DOWN_RIGHT = 2'd1;
  localparam logic [1:0] DIR_VERTICAL   = 2'd2;
  localparam logic [1:0] DIR_DOWN_LEFT  = 2'd3;

  localparam int CMDQ_DEPTH     = 4;
  localparam int CMDQ_PTR_BITS  = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_BITS  = $clog2(CMDQ_DEPTH + 1);
  localparam int OUT_DEPTH      = 8;
  localparam int OUT_PTR_BITS   = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_BITS   = $clog2(OUT_DEPTH + 1);
  localparam int OUT_POP_LIMIT  = OUT_DEPTH - 4;
  localparam int OUT_S1_LIMIT   = OUT_DEPTH - 2;

  typedef struct packed {
    logic                          action;
    logic [SAMPLE_BITS-1:0]        magnitude;
    logic signed [GRAD_BITS-1:0]   grad_x;
    logic signed [GRAD_BITS-1:0]   grad_y;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] kept_magnitude;
    logic [1:0]             direction_class;
    logic                   end_of_frame;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_PIXEL,
    CMD_FLUSH,
    CMD_PRELOAD
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic [COL_BITS-1:0]    rd_addr;
    logic [SAMPLE_BITS-1:0] mag;
    logic [1:0]             dir;
    logic                   emit_a;
    logic                   emit_b;
    logic                   a_left;
    logic                   a_right;
    logic                   b_left;
    logic                   has_up;
    logic                   eof;
  } cmd_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] up;
    logic [SAMPLE_BITS-1:0] mid;
    logic [1:0]             dir;
  } line_entry_t;

  localparam int LINE_BITS = $bits(line_entry_t);

  function automatic logic [1:0] classify(input logic signed [GRAD_BITS-1:0] gx,
                                          input logic signed [GRAD_BITS-1:0] gy);
    logic [GRAD_BITS:0]  ax;
    logic [GRAD_BITS:0]  ay;
    logic [PROD_BITS-1:0] ax_s;
    logic [PROD_BITS-1:0] ay_s;
    logic [PROD_BITS-1:0] ax_t;
    logic [PROD_BITS-1:0] ay_t;
    logic [1:0]          d;
    ax = gx[GRAD_BITS-1] ? ({1'b0, ~gx} + (GRAD_BITS+1)'(1)) : {1'b0, gx};
    ay = gy[GRAD_BITS-1] ? ({1'b0, ~gy} + (GRAD_BITS+1)'(1)) : {1'b0, gy};
    ax_s = {ax, TAN_SHIFT'(0)};
    ay_s = {ay, TAN_SHIFT'(0)};
    ax_t = PROD_BITS'(ax) * PROD_BITS'(TAN_NUM);
    ay_t = PROD_BITS'(ay) * PROD_BITS'(TAN_NUM);
    if (ay_s <= ax_t) begin
      d = DIR_HORIZONTAL;
    end else if (ax_s < ay_t) begin
      d = DIR_VERTICAL;
    end else if (gx[GRAD_BITS-1] == gy[GRAD_BITS-1]) begin
      d = DIR_DOWN_RIGHT;
    end else begin
      d = DIR_DOWN_LEFT;
    end
    return d;
  endfunction

  function automatic logic suppressed(input logic [1:0] dir,
                                      input logic [SAMPLE_BITS-1:0] ctr,
                                      input logic [SAMPLE_BITS-1:0] ul,
                                      input logic [SAMPLE_BITS-1:0] uc,
                                      input logic [SAMPLE_BITS-1:0] ur,
                                      input logic [SAMPLE_BITS-1:0] ml,
                                      input logic [SAMPLE_BITS-1:0] mr,
                                      input logic [SAMPLE_BITS-1:0] ll,
                                      input logic [SAMPLE_BITS-1:0] lc,
                                      input logic [SAMPLE_BITS-1:0] lr,
                                      input logic hl, input logic hr,
                                      input logic up, input logic down);
    logic s;
    unique case (dir)
      DIR_HORIZONTAL: s = (hl && ml > ctr) || (hr && mr > ctr);
      DIR_DOWN_RIGHT: s = (up && hl && ul > ctr) || (down && hr && lr > ctr);
      DIR_VERTICAL:   s = (up && uc > ctr) || (down && lc > ctr);
      default:        s = (up && hr && ur > ctr) || (down && hl && ll > ctr);
    endcase
    return s;
  endfunction

endpackage

// ----- hdl/ednms_front.sv -----
// Front end: configuration registers, raster counters, direction classing, command issue
`timescale 1ns / 1ps
module ednms_front
  import ednms_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  in_item_t                item,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data,
  output logic                    q_push,
  output cmd_t                    q_cmd,
  input  logic                    q_full
);

  logic [CFG_BITS-1:0] frame_width;
  logic [CFG_BITS-1:0] frame_height;
  logic [COL_BITS-1:0] col_cnt, col_cnt_next;
  logic [ROW_BITS-1:0] row_cnt, row_cnt_next;
  logic [COL_BITS-1:0] flush_cnt, flush_cnt_next;
  logic                flushing, flushing_next;
  logic                preload_pending, preload_pending_next;

  logic [CFG_BITS-1:0] width_eff;
  logic [CFG_BITS-1:0] height_eff;
  logic                last_col, last_row, flush_last, accept;

  always_comb begin
    if (frame_width == '0) width_eff = CFG_BITS'(1);
    else if (frame_width > WIDTH_LIMIT) width_eff = WIDTH_LIMIT;
    else width_eff = frame_width;
    if (frame_height == '0) height_eff = CFG_BITS'(1);
    else if (frame_height > HEIGHT_LIMIT) height_eff = HEIGHT_LIMIT;
    else height_eff = frame_height;
  end

  assign last_col   = (CFG_BITS'(col_cnt) + CFG_BITS'(1)) >= width_eff;
  assign last_row   = (CFG_BITS'(row_cnt) + CFG_BITS'(1)) >= height_eff;
  assign flush_last = (CFG_BITS'(flush_cnt) + CFG_BITS'(1)) >= width_eff;
  assign full       = q_full || preload_pending;
  assign accept     = push && !full;

  always_comb begin
    col_cnt_next         = col_cnt;
    row_cnt_next         = row_cnt;
    flush_cnt_next       = flush_cnt;
    flushing_next        = flushing;
    preload_pending_next = preload_pending;
    q_push               = 1'b0;
    q_cmd                = '0;
    q_cmd.kind           = CMD_PRELOAD;
    priority if (preload_pending && !q_full) begin
      q_push               = 1'b1;
      preload_pending_next = 1'b0;
    end else if (accept && item.action == ACT_FLUSH && flushing) begin
      q_push         = 1'b1;
      q_cmd.kind     = CMD_FLUSH;
      q_cmd.rd_addr  = flush_cnt + COL_BITS'(1);
      q_cmd.emit_a   = 1'b1;
      q_cmd.a_left   = flush_cnt != '0;
      q_cmd.a_right  = !flush_last;
      q_cmd.has_up   = row_cnt != '0;
      q_cmd.eof      = flush_last;
      if (flush_last) begin
        flushing_next  = 1'b0;
        col_cnt_next   = '0;
        row_cnt_next   = '0;
        flush_cnt_next = '0;
      end else begin
        flush_cnt_next = flush_cnt + COL_BITS'(1);
      end
    end else if (accept && item.action == ACT_PIXEL && !flushing) begin
      q_push        = 1'b1;
      q_cmd.kind    = CMD_PIXEL;
      q_cmd.rd_addr = col_cnt;
      q_cmd.mag     = item.magnitude;
      q_cmd.dir     = classify(item.grad_x, item.grad_y);
      q_cmd.emit_a  = (row_cnt != '0) && (col_cnt != '0);
      q_cmd.emit_b  = (row_cnt != '0) && last_col;
      q_cmd.a_left  = col_cnt > COL_BITS'(1);
      q_cmd.a_right = 1'b1;
      q_cmd.b_left  = col_cnt != '0;
      q_cmd.has_up  = row_cnt > ROW_BITS'(1);
      if (last_col) begin
        col_cnt_next = '0;
        if (last_row) begin
          flushing_next        = 1'b1;
          flush_cnt_next       = '0;
          preload_pending_next = 1'b1;
        end else begin
          row_cnt_next = row_cnt + ROW_BITS'(1);
        end
      end else begin
        col_cnt_next = col_cnt + COL_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width     <= RESET_FRAME_WIDTH;
      frame_height    <= RESET_FRAME_HEIGHT;
      col_cnt         <= '0;
      row_cnt         <= '0;
      flush_cnt       <= '0;
      flushing        <= 1'b0;
      preload_pending <= 1'b0;
    end else begin
      col_cnt         <= col_cnt_next;
      row_cnt         <= row_cnt_next;
      flush_cnt       <= flush_cnt_next;
      flushing        <= flushing_next;
      preload_pending <= preload_pending_next;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_FRAME_WIDTH:  frame_width  <= cfg_data;
          REG_FRAME_HEIGHT: frame_height <= cfg_data;
          default:          frame_height <= cfg_data;
        endcase
      end
    end
  end

  a_preload_in_flush: assert property (@(posedge clk) disable iff (rst)
    preload_pending |-> flushing) else $error("preload pending outside flush");

  a_flush_cnt_idle: assert property (@(posedge clk) disable iff (rst)
    !flushing |-> flush_cnt == '0) else $error("flush counter moved outside flush");

endmodule

// ----- hdl/ednms_cmdq.sv -----
// Short command queue between front end and back end
`timescale 1ns / 1ps
module ednms_cmdq
  import ednms_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t dout
);

  cmd_t                     entries [CMDQ_DEPTH];
  logic [CMDQ_PTR_BITS-1:0] wr_ptr;
  logic [CMDQ_PTR_BITS-1:0] rd_ptr;
  logic [CMDQ_CNT_BITS-1:0] count;
  logic                     do_push, do_pop;

  assign full    = count == CMDQ_CNT_BITS'(CMDQ_DEPTH);
  assign valid   = count != '0;
  assign dout    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + CMDQ_PTR_BITS'(1);
      if (do_pop)  rd_ptr <= rd_ptr + CMDQ_PTR_BITS'(1);
      count <= count + CMDQ_CNT_BITS'(do_push) - CMDQ_CNT_BITS'(do_pop);
    end
  end

  a_cmdq_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CMDQ_CNT_BITS'(CMDQ_DEPTH)) else $error("command queue overrun");

endmodule

// ----- hdl/ednms_ram.sv -----
// Generic simple dual-port RAM with registered read
`timescale 1ns / 1ps
module ednms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- hdl/ednms_back.sv -----
// Back end: line store, neighbour window, suppression and result queue
`timescale 1ns / 1ps
module ednms_back
  import ednms_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  output logic      q_pop,
  input  cmd_t      q_cmd,
  output logic      empty,
  input  logic      pop,
  output out_item_t result
);

  logic                    s1_valid;
  cmd_t                    s1;
  line_entry_t             ram_q;
  line_entry_t             byp_data;
  logic                    byp_hit;
  line_entry_t             d;
  line_entry_t             w0, w1;
  logic [SAMPLE_BITS-1:0]  lm1, lm2;
  line_entry_t             wr_data;
  logic                    wr_en;

  out_item_t                out_mem [OUT_DEPTH];
  logic [OUT_PTR_BITS-1:0]  wr_ptr, rd_ptr;
  logic [OUT_CNT_BITS-1:0]  out_count;
  out_item_t                res_a, res_b;
  logic                     push_a, push_b, pop_fire, is_pixel;

  assign q_pop    = q_valid && (out_count <= OUT_CNT_BITS'(OUT_POP_LIMIT));
  assign is_pixel = s1.kind == CMD_PIXEL;
  assign wr_en    = s1_valid && is_pixel;
  assign d        = byp_hit ? byp_data : ram_q;
  assign wr_data  = '{up: d.mid, mid: s1.mag, dir: s1.dir};

  ednms_ram #(
    .WIDTH (LINE_BITS),
    .DEPTH (MAX_LINE_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1.rd_addr),
    .wr_data (wr_data),
    .rd_addr (q_cmd.rd_addr),
    .rd_data (ram_q)
  );

  always_comb begin
    res_a.kept_magnitude  = suppressed(w0.dir, w0.mid, w1.up, w0.up, d.up, w1.mid, d.mid,
                                       lm2, lm1, s1.mag, s1.a_left, s1.a_right,
                                       s1.has_up, is_pixel) ? '0 : w0.mid;
    res_a.direction_class = w0.dir;
    res_a.end_of_frame    = s1.eof;
    res_b.kept_magnitude  = suppressed(d.dir, d.mid, w0.up, d.up, '0, w0.mid, '0,
                                       lm1, s1.mag, '0, s1.b_left, 1'b0,
                                       s1.has_up, 1'b1) ? '0 : d.mid;
    res_b.direction_class = d.dir;
    res_b.end_of_frame    = 1'b0;
  end

  assign push_a   = s1_valid && s1.emit_a;
  assign push_b   = s1_valid && s1.emit_b;
  assign empty    = out_count == '0;
  assign pop_fire = pop && !empty;
  assign result   = out_mem[rd_ptr];

  always_ff @(posedge clk) begin
    s1       <= q_cmd;
    byp_hit  <= wr_en && (q_cmd.rd_addr == s1.rd_addr);
    byp_data <= wr_data;
    if (s1_valid) begin
      w1 <= w0;
      w0 <= d;
      if (is_pixel) begin
        lm2 <= lm1;
        lm1 <= s1.mag;
      end
    end
    if (push_a) out_mem[wr_ptr] <= res_a;
    if (push_b) out_mem[push_a ? wr_ptr + OUT_PTR_BITS'(1) : wr_ptr] <= res_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      out_count <= '0;
    end else begin
      s1_valid  <= q_pop;
      wr_ptr    <= wr_ptr + OUT_PTR_BITS'(push_a) + OUT_PTR_BITS'(push_b);
      if (pop_fire) rd_ptr <= rd_ptr + OUT_PTR_BITS'(1);
      out_count <= out_count + OUT_CNT_BITS'(push_a) + OUT_CNT_BITS'(push_b)
                   - OUT_CNT_BITS'(pop_fire);
    end
  end

  a_out_bound: assert property (@(posedge clk) disable iff (rst)
    out_count <= OUT_CNT_BITS'(OUT_DEPTH)) else $error("result queue overrun");

  a_s1_room: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> out_count <= OUT_CNT_BITS'(OUT_S1_LIMIT))
    else $error("no room for stage results");

endmodule

// ----- hdl/edge_non_maximum_suppression.sv -----
// Top level of the streaming 3x3 edge non-maximum suppression block
//
// Input queue port: push/full with one item per transaction. A pixel item
// carries magnitude and x/y gradients in raster order; a flush item releases
// one result of the frame's last row after the frame's final pixel.
// Result queue port: empty/pop; the oldest result waits on result while
// empty is low. A pixel releases the result of the pixel above-left of it,
// the last pixel of a row also the one above it.
// Configuration: cfg_write/cfg_index/cfg_data set frame width (index 0) and
// height (index 1); write only while idle. Reset gives 640 x 480.
// Throughput: one item per cycle while full is low, set by the single read
// and write port of the line store; after each frame's final pixel full is
// raised while the line store is primed for the flush. An accepted item goes
// through the command queue and stage s1 into the result queue. A stalled
// result port fills the result queue, then the command queue, then raises
// full. Reset clears all control state; the line store is not cleared.
`timescale 1ns / 1ps
module edge_non_maximum_suppression
  import ednms_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  in_item_t                item,
  output logic                    empty,
  input  logic                    pop,
  output out_item_t               result,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data
);

  logic f_push, f_full, b_valid, b_pop;
  cmd_t f_cmd, b_cmd;

  ednms_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_push    (f_push),
    .q_cmd     (f_cmd),
    .q_full    (f_full)
  );

  ednms_cmdq u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .din   (f_cmd),
    .full  (f_full),
    .pop   (b_pop),
    .valid (b_valid),
    .dout  (b_cmd)
  );

  ednms_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (b_valid),
    .q_pop   (b_pop),
    .q_cmd   (b_cmd),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule
